// ===== rtl/i2cm_pkg.sv =====
// Shared types and codes for the I2C EEPROM master core.
// No dependencies; imported by i2cm_phase_fsm and i2c_eeprom_master_core.
package i2cm_pkg;

    // Action codes carried in the request
    localparam logic [1:0] ACT_ADVANCE = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    // Configuration register map (word index from paddr[2])
    localparam logic       REG_DEVICE_ADDRESS = 1'b0;
    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd80;

    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned APB_ADDR_W = 3;

    // One input request, one bus phase tick
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] start_address;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_in;
    } cmd_t;

    // Result of one tick
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       byte_taken;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       ack_error;
        logic       busy_res;
        logic       done_res;
    } res_t;

endpackage

// ===== rtl/i2c_eeprom_master_core.sv =====
// I2C master for a 24C02-style serial EEPROM, one bus phase per request.
//
// Usage: each request on the s_ channel is one bus phase tick. Action 1 or
// 2 in idle begins a write or read transaction with the given word address
// and byte count; any other request advances the bus by one phase, with
// sda_in giving the data line level sampled in the current phase. Every
// request yields exactly one response on the m_ channel carrying scl and
// sda levels for the phase entered, the byte_taken strobe (write_byte was
// consumed), completed read bytes, the last acknowledge level, busy and done.
// The response is registered and appears in the cycle after the request is accepted.
// One request per cycle when not stalled; state advances in a single pass of
// the phase sequencer between the request edge and the response register.
// When the receiver stalls, the response register holds and s_tready drops
// until it is taken. The device address register sits at APB offset 0 and
// should be written only while idle. Reset (aresetn low, synchronous)
// returns the sequencer to idle, empties the response register and sets
// the device address to 0x50.
module i2c_eeprom_master_core
    import i2cm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // request: [1:0] action, [9:2] start_address, [17:10] byte_count,
    //          [25:18] write_byte, [26] sda_in, [31:27] zero
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // response: [0] scl, [1] sda_out, [2] byte_taken, [10:3] read_byte,
    //           [11] read_valid, [12] ack_error, [13] busy_res,
    //           [14] done_res, [15] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cmd_t       cmd;
    res_t       res;
    logic       step;
    logic       cfg_write;
    logic [6:0] device_address_reg;
    logic       m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // Unpack request fields
    assign cmd.action        = s_tdata[1:0];
    assign cmd.start_address = s_tdata[9:2];
    assign cmd.byte_count    = s_tdata[17:10];
    assign cmd.write_byte    = s_tdata[25:18];
    assign cmd.sda_in        = s_tdata[26];

    // Accept while the response slot is free or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    i2cm_phase_fsm u_fsm (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .cmd            (cmd),
        .device_address (device_address_reg),
        .res            (res)
    );

    // Response register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_tdata_reg <= {1'b0, res.done_res, res.busy_res, res.ack_error,
                            res.read_valid, res.read_byte, res.byte_taken,
                            res.sda_out, res.scl};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // APB register: device address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == REG_DEVICE_ADDRESS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= DEVICE_ADDRESS_RST;
        end else if (cfg_write) begin
            device_address_reg <= pwdata[6:0];
        end
    end

    assign prdata = (paddr[2] == REG_DEVICE_ADDRESS) ? {25'd0, device_address_reg} : 32'd0;

    // paddr[1:0] is a byte offset inside the word and does not select a register;
    // the request pad bits carry nothing
    logic unused_addr;
    assign unused_addr = ^{paddr[1:0], pwdata[31:7], s_tdata[IN_DATA_W-1:27]};

endmodule

// ===== rtl/i2cm_phase_fsm.sv =====
// Bus phase sequencer of the I2C EEPROM master: holds transaction state and
// computes the line levels and status of the phase entered on each tick.
// Depends on i2cm_pkg.
module i2cm_phase_fsm
    import i2cm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  cmd_t       cmd,
    input  logic [6:0] device_address,
    output res_t       res
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_S0      = 4'd1,
        PH_S1      = 4'd2,
        PH_S2      = 4'd3,
        PH_S3      = 4'd4,
        PH_TX_LO   = 4'd5,
        PH_TX_HI   = 4'd6,
        PH_ACK_LO  = 4'd7,
        PH_ACK_HI  = 4'd8,
        PH_RX_LO   = 4'd9,
        PH_RX_HI   = 4'd10,
        PH_MACK_LO = 4'd11,
        PH_MACK_HI = 4'd12,
        PH_P0      = 4'd13,
        PH_P1      = 4'd14
    } phase_t;

    typedef enum logic [1:0] {
        ST_DEVW  = 2'd0,
        ST_WADDR = 2'd1,
        ST_DEVR  = 2'd2,
        ST_DATA  = 2'd3
    } stage_t;

    phase_t     phase_reg, phase_next;
    stage_t     stage_reg, stage_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [7:0] shifter_reg, shifter_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] word_address_reg, word_address_next;
    logic       read_mode_reg, read_mode_next;
    logic       last_ack_reg, last_ack_next;

    logic [7:0] waddr_byte;
    logic [7:0] bytes_dec;
    logic       taken;
    logic       rvalid;
    logic       done;
    logic       scl;
    logic       sdo;
    logic       mack_sdo;

    assign waddr_byte = {device_address, 1'b0};
    assign bytes_dec  = (bytes_left_reg != 8'd0) ? bytes_left_reg - 8'd1 : bytes_left_reg;

    // Phase transitions and data path for one tick
    always_comb begin
        phase_next        = phase_reg;
        stage_next        = stage_reg;
        bit_index_next    = bit_index_reg;
        shifter_next      = shifter_reg;
        bytes_left_next   = bytes_left_reg;
        word_address_next = word_address_reg;
        read_mode_next    = read_mode_reg;
        last_ack_next     = last_ack_reg;
        taken             = 1'b0;
        rvalid            = 1'b0;
        done              = 1'b0;

        case (phase_reg)
            PH_IDLE: begin
                if (cmd.action == ACT_WRITE || cmd.action == ACT_READ) begin
                    word_address_next = cmd.start_address;
                    bytes_left_next   = cmd.byte_count;
                    read_mode_next    = (cmd.action == ACT_READ);
                    stage_next        = ST_DEVW;
                    phase_next        = PH_S1;
                end
            end
            PH_S0: phase_next = PH_S1;
            PH_S1: phase_next = PH_S2;
            PH_S2: phase_next = PH_S3;
            PH_S3: begin
                shifter_next   = (stage_reg == ST_DEVR) ? (waddr_byte | 8'h01) : waddr_byte;
                bit_index_next = 3'd0;
                phase_next     = PH_TX_LO;
            end
            PH_TX_LO: phase_next = PH_TX_HI;
            PH_TX_HI: begin
                if (bit_index_reg != 3'd7) begin
                    bit_index_next = bit_index_reg + 3'd1;
                    shifter_next   = {shifter_reg[6:0], 1'b0};
                    phase_next     = PH_TX_LO;
                end else begin
                    phase_next = PH_ACK_LO;
                end
            end
            PH_ACK_LO: begin
                phase_next    = PH_ACK_HI;
                last_ack_next = cmd.sda_in;
            end
            PH_ACK_HI: begin
                case (stage_reg)
                    ST_DEVW: begin
                        stage_next     = ST_WADDR;
                        shifter_next   = word_address_reg;
                        bit_index_next = 3'd0;
                        phase_next     = PH_TX_LO;
                    end
                    ST_WADDR: begin
                        if (read_mode_reg) begin
                            stage_next = ST_DEVR;
                            phase_next = PH_S0;
                        end else if (bytes_left_reg != 8'd0) begin
                            stage_next     = ST_DATA;
                            shifter_next   = cmd.write_byte;
                            bit_index_next = 3'd0;
                            phase_next     = PH_TX_LO;
                            taken          = 1'b1;
                        end else begin
                            phase_next = PH_P0;
                        end
                    end
                    ST_DATA: begin
                        bytes_left_next = bytes_dec;
                        if (bytes_dec != 8'd0) begin
                            shifter_next   = cmd.write_byte;
                            bit_index_next = 3'd0;
                            phase_next     = PH_TX_LO;
                            taken          = 1'b1;
                        end else begin
                            phase_next = PH_P0;
                        end
                    end
                    default: begin
                        // read address sent: start receiving or stop
                        if (bytes_left_reg != 8'd0) begin
                            shifter_next   = 8'd0;
                            bit_index_next = 3'd0;
                            phase_next     = PH_RX_LO;
                        end else begin
                            phase_next = PH_P0;
                        end
                    end
                endcase
            end
            PH_RX_LO: begin
                phase_next   = PH_RX_HI;
                shifter_next = {shifter_reg[6:0], cmd.sda_in};
                rvalid       = (bit_index_reg == 3'd7);
            end
            PH_RX_HI: begin
                if (bit_index_reg != 3'd7) begin
                    bit_index_next = bit_index_reg + 3'd1;
                    phase_next     = PH_RX_LO;
                end else begin
                    phase_next = PH_MACK_LO;
                end
            end
            PH_MACK_LO: phase_next = PH_MACK_HI;
            PH_MACK_HI: begin
                bytes_left_next = bytes_dec;
                if (bytes_dec != 8'd0) begin
                    shifter_next   = 8'd0;
                    bit_index_next = 3'd0;
                    phase_next     = PH_RX_LO;
                end else begin
                    phase_next = PH_P0;
                end
            end
            PH_P0: phase_next = PH_P1;
            PH_P1: begin
                phase_next = PH_IDLE;
                done       = 1'b1;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // Line levels of the phase being entered
    assign mack_sdo = (bytes_left_next <= 8'd1);

    always_comb begin
        case (phase_next)
            PH_S0:      begin scl = 1'b0; sdo = 1'b1;             end
            PH_S2:      begin scl = 1'b1; sdo = 1'b0;             end
            PH_S3:      begin scl = 1'b0; sdo = 1'b0;             end
            PH_TX_LO:   begin scl = 1'b0; sdo = shifter_next[7];  end
            PH_TX_HI:   begin scl = 1'b1; sdo = shifter_next[7];  end
            PH_ACK_LO:  begin scl = 1'b0; sdo = 1'b1;             end
            PH_RX_LO:   begin scl = 1'b0; sdo = 1'b1;             end
            PH_MACK_LO: begin scl = 1'b0; sdo = mack_sdo;         end
            PH_MACK_HI: begin scl = 1'b1; sdo = mack_sdo;         end
            PH_P0:      begin scl = 1'b0; sdo = 1'b0;             end
            PH_P1:      begin scl = 1'b1; sdo = 1'b0;             end
            default:    begin scl = 1'b1; sdo = 1'b1;             end
        endcase
    end

    assign res.scl        = scl;
    assign res.sda_out    = sdo;
    assign res.byte_taken = taken;
    assign res.read_byte  = rvalid ? shifter_next : 8'd0;
    assign res.read_valid = rvalid;
    assign res.ack_error  = last_ack_next;
    assign res.busy_res   = (phase_next != PH_IDLE);
    assign res.done_res   = done;

    // State registers advance once per accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            stage_reg        <= ST_DEVW;
            bit_index_reg    <= 3'd0;
            shifter_reg      <= 8'd0;
            bytes_left_reg   <= 8'd0;
            word_address_reg <= 8'd0;
            read_mode_reg    <= 1'b0;
            last_ack_reg     <= 1'b0;
        end else if (step) begin
            phase_reg        <= phase_next;
            stage_reg        <= stage_next;
            bit_index_reg    <= bit_index_next;
            shifter_reg      <= shifter_next;
            bytes_left_reg   <= bytes_left_next;
            word_address_reg <= word_address_next;
            read_mode_reg    <= read_mode_next;
            last_ack_reg     <= last_ack_next;
        end
    end

`ifndef SYNTHESIS
    // stop completes only out of the second stop phase
    a_done_from_p1: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.done_res) |-> (phase_reg == PH_P1))
        else $error("done raised outside stop phase");

    // a begin from idle always enters the start sequence
    a_begin_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == PH_IDLE &&
         (cmd.action == ACT_WRITE || cmd.action == ACT_READ)) |=> (phase_reg == PH_S1))
        else $error("begin did not enter start sequence");

    // data bytes are pulled only after an acknowledge slot
    a_taken_after_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.byte_taken) |-> (phase_reg == PH_ACK_HI && !read_mode_reg))
        else $error("write byte taken outside acknowledge slot");

    // a read byte completes on its eighth sampled bit
    a_rvalid_bit7: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.read_valid) |-> (phase_reg == PH_RX_LO && bit_index_reg == 3'd7))
        else $error("read byte completed early");
`endif

endmodule
